### design/bap_pkg.sv
// shared types, constants and helpers of the block average pixelizer
package bap_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int MaxShift  = 6;
	localparam int StoreDepth = MaxWidth / 2;
	localparam int IdxW      = $clog2(StoreDepth);
	localparam int SumW      = 20;
	localparam int CntW      = 2 * MaxShift + 1;
	localparam int DivSteps  = SumW;
	localparam int StepW     = $clog2(DivSteps);

	localparam logic [1:0] REG_SHIFT  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	// index with no register behind it
	localparam logic [1:0] REG_SPARE  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pass;
		logic last;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic [CntW-1:0] rem;
		logic [SumW-1:0] quo;
	} div_t;

	// one restoring division step: shift in next dividend bit, try subtract
	function automatic div_t div_step(input div_t d, input logic [CntW-1:0] cnt);
		logic [CntW:0] sh;
		logic [CntW:0] trial;
		div_t r;
		sh = {d.rem, d.quo[SumW-1]};
		trial = sh - {1'b0, cnt};
		r.quo = {d.quo[SumW-2:0], ~trial[CntW]};
		r.rem = trial[CntW] ? sh[CntW-1:0] : trial[CntW-1:0];
		return r;
	endfunction

endpackage

### design/block_average_pixelize_core.sv
// top level of the block average pixelizer
// Takes RGB pixels in raster order and emits one request per finished square
// block (side 2^block_shift, shift capped at 6, clipped at the right and bottom
// edges) holding the block's truncated channel means; with block_shift 0 every
// pixel comes back as its own 1x1 block. A pixel that does not end a block is
// accepted, then does one read-modify-write of the per-column sum store; shift 0
// then loads the output; a block-ending pixel runs the 20-step restoring divider
// that splits each sum by the clipped pixel count, then the output load. A finished
// result sits in the output register while the next pixel is taken. Config
// writes (always ready) restart the frame at the top left; write only while idle.
module block_average_pixelize_core (
	input  logic        clk,
	input  logic        arst_n,
	// pixel requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	// block results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // block_column[9:0], block_row[19:10],
	                               // block_width[26:20], block_height[33:27],
	                               // avg_red[41:34], avg_green[49:42],
	                               // avg_blue[57:50], zeros[63:58]
	output logic        m_tlast,   // frame_last
	// register writes: 0 block_shift, 1 image_width, 2 image_height
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	bap_pkg::cmd_t  cmd;
	bap_pkg::stat_t stat;

	// registers are accepted in any cycle
	assign cfg_ready = 1'b1;

	bap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bap_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### design/bap_ctrl.sv
// controller state machine of the block average pixelizer
module bap_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  bap_pkg::stat_t  stat,
	output bap_pkg::cmd_t   cmd
);

	bap_pkg::state_t state_q, state_d;
	logic [bap_pkg::StepW-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bap_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bap_pkg::ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bap_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = bap_pkg::ST_UPD;
			end
			bap_pkg::ST_UPD: begin
				if (stat.pass) state_d = bap_pkg::ST_OUT;
				else if (stat.last) state_d = bap_pkg::ST_DIV;
				else state_d = bap_pkg::ST_IDLE;
			end
			bap_pkg::ST_DIV: begin
				if (step_q == bap_pkg::StepW'(bap_pkg::DivSteps - 1)) state_d = bap_pkg::ST_OUT;
			end
			bap_pkg::ST_OUT: begin
				if (stat.out_free) state_d = bap_pkg::ST_IDLE;
			end
			default: state_d = bap_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == bap_pkg::ST_IDLE);
		cmd.accept   = s_tready && s_tvalid;
		cmd.update   = (state_q == bap_pkg::ST_UPD);
		cmd.div_step = (state_q == bap_pkg::ST_DIV);
		cmd.out_load = (state_q == bap_pkg::ST_OUT) && stat.out_free;
	end

endmodule

### design/bap_datapath.sv
// datapath: config, raster position, sum store, divider lanes, output register
module bap_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [23:0]    s_tdata,
	input  logic           cfg_valid,
	input  logic [1:0]     cfg_index,
	input  logic [10:0]    cfg_data,
	input  bap_pkg::cmd_t  cmd,
	output bap_pkg::stat_t stat,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [63:0]    m_tdata,
	output logic           m_tlast
);

	logic [2:0]  shift_q;
	logic [10:0] width_q, height_q;
	logic [9:0]  col_q, row_q;

	logic [2:0]  s_eff;
	logic [10:0] w_eff, h_eff;
	logic [9:0]  col_c, row_c, mask, xin, yin, base_x, base_y, bc, br;
	logic [6:0]  side, bw, bh;
	logic [10:0] rem_w, rem_h;
	logic        is_first, is_last, is_flast;

	logic [23:0] pix_q;
	logic [9:0]  bc_q, br_q;
	logic [6:0]  bw_q, bh_q;
	logic        first_q, last_q, flast_q, pass_q;
	logic [bap_pkg::IdxW-1:0] idx_q;

	logic [3*bap_pkg::SumW-1:0] mem [bap_pkg::StoreDepth];
	logic [3*bap_pkg::SumW-1:0] rd_s1, sums;
	logic [bap_pkg::CntW-1:0]   cnt_q;
	bap_pkg::div_t lane_q [3];

	logic out_free;

	assign s_eff = (shift_q > 3'(bap_pkg::MaxShift)) ? 3'(bap_pkg::MaxShift) : shift_q;
	assign w_eff = (width_q == '0) ? 11'd1 :
		(width_q > 11'(bap_pkg::MaxWidth)) ? 11'(bap_pkg::MaxWidth) : width_q;
	assign h_eff = (height_q == '0) ? 11'd1 :
		(height_q > 11'(bap_pkg::MaxHeight)) ? 11'(bap_pkg::MaxHeight) : height_q;

	always_comb begin
		col_c    = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
		row_c    = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
		side     = 7'd1 << s_eff;
		mask     = {3'b0, side} - 10'd1;
		xin      = col_c & mask;
		yin      = row_c & mask;
		base_x   = col_c & ~mask;
		base_y   = row_c & ~mask;
		bc       = col_c >> s_eff;
		br       = row_c >> s_eff;
		rem_w    = w_eff - {1'b0, base_x};
		rem_h    = h_eff - {1'b0, base_y};
		bw       = (rem_w > {4'b0, side}) ? side : rem_w[6:0];
		bh       = (rem_h > {4'b0, side}) ? side : rem_h[6:0];
		is_first = (xin == '0) && (yin == '0);
		is_last  = (xin == {3'b0, bw} - 10'd1) && (yin == {3'b0, bh} - 10'd1);
		is_flast = ({1'b0, col_c} == w_eff - 11'd1) && ({1'b0, row_c} == h_eff - 11'd1);
	end

	// config registers and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			width_q  <= 11'd640;
			height_q <= 11'd480;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_valid && cfg_index != bap_pkg::REG_SPARE) begin
			unique case (cfg_index)
				bap_pkg::REG_SHIFT:  shift_q  <= cfg_data[2:0];
				bap_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bap_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if ({1'b0, col_c} + 11'd1 >= w_eff) begin
				col_q <= '0;
				row_q <= ({1'b0, row_c} + 11'd1 >= h_eff) ? '0 : row_c + 10'd1;
			end else begin
				col_q <= col_c + 10'd1;
				row_q <= row_c;
			end
		end
	end

	// request capture and store read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q   <= s_tdata;
			bc_q    <= bc;
			br_q    <= br;
			bw_q    <= bw;
			bh_q    <= bh;
			first_q <= is_first;
			last_q  <= is_last;
			flast_q <= is_flast;
			pass_q  <= (s_eff == '0);
			idx_q   <= bc[bap_pkg::IdxW-1:0];
			rd_s1   <= mem[bc[bap_pkg::IdxW-1:0]];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sums[c*bap_pkg::SumW +: bap_pkg::SumW] = first_q ?
				bap_pkg::SumW'(pix_q[c*8 +: 8]) :
				rd_s1[c*bap_pkg::SumW +: bap_pkg::SumW] + bap_pkg::SumW'(pix_q[c*8 +: 8]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && !pass_q) begin
			mem[idx_q] <= sums;
		end
	end

	// three divider lanes share one count
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			cnt_q <= bap_pkg::CntW'(bw_q) * bap_pkg::CntW'(bh_q);
			for (int c = 0; c < 3; c++) begin
				lane_q[c].rem <= '0;
				lane_q[c].quo <= pass_q ? bap_pkg::SumW'(pix_q[c*8 +: 8]) :
					sums[c*bap_pkg::SumW +: bap_pkg::SumW];
			end
		end else if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				lane_q[c] <= bap_pkg::div_step(lane_q[c], cnt_q);
			end
		end
	end

	// output register
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {6'b0, lane_q[2].quo[7:0], lane_q[1].quo[7:0], lane_q[0].quo[7:0],
				bh_q, bw_q, br_q, bc_q};
			m_tlast <= flast_q;
		end
	end

	assign stat.pass     = pass_q;
	assign stat.last     = last_q;
	assign stat.out_free = out_free;

endmodule

### bench/tb_top.sv
// self-checking bench for the block average pixelizer core
module tb_top;

	typedef struct packed {
		logic [9:0] col;
		logic [9:0] row;
		logic [6:0] bw;
		logic [6:0] bh;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} block_res_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [1:0] idx;
		logic [10:0] val;
		logic [23:0] rgb;
		bit         typed;
		block_res_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	block_average_pixelize_core uut (.*);

	always #5 clk = ~clk;

	// mirror of the block state
	logic [2:0]  mir_shift;
	logic [10:0] mir_width;
	logic [10:0] mir_height;
	logic [19:0] sum_r [bap_pkg::StoreDepth];
	logic [19:0] sum_g [bap_pkg::StoreDepth];
	logic [19:0] sum_b [bap_pkg::StoreDepth];
	int unsigned pos_col, pos_row;

	block_res_t pending_blocks[$];
	int errors = 0;
	int send_idle = 22;
	int recv_idle = 59;
	int pixels_sent = 0;
	dir_row_t dir_rows[$];

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	// computes the block result a pixel causes, if any, and advances the raster
	task automatic average_pixel(input logic [23:0] rgb, output bit got, output block_res_t res);
		int unsigned w, h, s, side, bc, br, xin, yin, bw, bh, idx, cnt, c, r;
		w = (mir_width == 0) ? 1 :
			(mir_width > bap_pkg::MaxWidth ? bap_pkg::MaxWidth : mir_width);
		h = (mir_height == 0) ? 1 :
			(mir_height > bap_pkg::MaxHeight ? bap_pkg::MaxHeight : mir_height);
		s = (mir_shift > bap_pkg::MaxShift) ? bap_pkg::MaxShift : mir_shift;
		if (pos_col >= w) pos_col = 0;
		if (pos_row >= h) pos_row = 0;
		c = pos_col;
		r = pos_row;
		side = 1 << s;
		bc = c >> s;
		br = r >> s;
		xin = c & (side - 1);
		yin = r & (side - 1);
		bw = w - bc * side;
		if (bw > side) bw = side;
		bh = h - br * side;
		if (bh > side) bh = side;
		got = 0;
		res = '0;
		if (s == 0) begin
			got = 1;
			res.red = rgb[7:0];
			res.green = rgb[15:8];
			res.blue = rgb[23:16];
		end else begin
			idx = (bc >= bap_pkg::StoreDepth) ? bap_pkg::StoreDepth - 1 : bc;
			if (xin == 0 && yin == 0) begin
				sum_r[idx] = rgb[7:0];
				sum_g[idx] = rgb[15:8];
				sum_b[idx] = rgb[23:16];
			end else begin
				sum_r[idx] = sum_r[idx] + rgb[7:0];
				sum_g[idx] = sum_g[idx] + rgb[15:8];
				sum_b[idx] = sum_b[idx] + rgb[23:16];
			end
			if (xin == bw - 1 && yin == bh - 1) begin
				cnt = bw * bh;
				got = 1;
				res.red = 8'(sum_r[idx] / cnt);
				res.green = 8'(sum_g[idx] / cnt);
				res.blue = 8'(sum_b[idx] / cnt);
			end
		end
		res.col = 10'(bc);
		res.row = 10'(br);
		res.bw = 7'(bw);
		res.bh = 7'(bh);
		res.last = (c == w - 1 && r == h - 1);
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		pos_col = c;
		pos_row = r;
	endtask

	// one pixel request; valid stays high into the next call unless a gap comes
	task automatic send_pixel(input logic [23:0] rgb, input bit typed, input block_res_t want);
		bit got;
		block_res_t res;
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rgb;
		do @(posedge clk); while (!s_tready);
		average_pixel(rgb, got, res);
		if (typed) pending_blocks.push_back(want);
		else if (got) pending_blocks.push_back(res);
		pixels_sent++;
	endtask

	// register write, only once every block is out and the core has settled
	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			bap_pkg::REG_SHIFT:  mir_shift = val[2:0];
			bap_pkg::REG_WIDTH:  mir_width = val;
			bap_pkg::REG_HEIGHT: mir_height = val;
			default: ;
		endcase
		// only the three known indexes restart the frame
		if (idx == bap_pkg::REG_SHIFT || idx == bap_pkg::REG_WIDTH ||
				idx == bap_pkg::REG_HEIGHT) begin
			pos_col = 0;
			pos_row = 0;
		end
	endtask

	task automatic add_row(input row_kind_t k, input logic [1:0] idx, input logic [10:0] val,
			input logic [23:0] rgb, input bit typed, input block_res_t want);
		dir_row_t d;
		d.kind = k;
		d.idx = idx;
		d.val = val;
		d.rgb = rgb;
		d.typed = typed;
		d.want = want;
		dir_rows.push_back(d);
	endtask

	// result side: random back-pressure and field checks
	always @(posedge clk) begin
		block_res_t got, want;
		m_tready <= ($urandom_range(99) >= recv_idle);
		if (arst_n && m_tvalid && m_tready) begin
			got.col = m_tdata[9:0];
			got.row = m_tdata[19:10];
			got.bw = m_tdata[26:20];
			got.bh = m_tdata[33:27];
			got.red = m_tdata[41:34];
			got.green = m_tdata[49:42];
			got.blue = m_tdata[57:50];
			got.last = m_tlast;
			if (pending_blocks.size() == 0) begin
				report($sformatf("unexpected block %h", got));
			end else begin
				want = pending_blocks.pop_front();
				if (got.col != want.col)
					report($sformatf("block_column %0d want %0d", got.col, want.col));
				if (got.row != want.row)
					report($sformatf("block_row %0d want %0d", got.row, want.row));
				if (got.bw != want.bw)
					report($sformatf("block_width %0d want %0d", got.bw, want.bw));
				if (got.bh != want.bh)
					report($sformatf("block_height %0d want %0d", got.bh, want.bh));
				if (got.red != want.red)
					report($sformatf("avg_red %0d want %0d", got.red, want.red));
				if (got.green != want.green)
					report($sformatf("avg_green %0d want %0d", got.green, want.green));
				if (got.blue != want.blue)
					report($sformatf("avg_blue %0d want %0d", got.blue, want.blue));
				if (got.last != want.last)
					report($sformatf("frame_last %0d want %0d", got.last, want.last));
			end
		end
	end

	// idle mix follows progress through the random part
	always @(posedge clk) begin
		if (pixels_sent > 1400) begin
			send_idle = 0;
			recv_idle = 0;
		end else if (pixels_sent > 700) begin
			send_idle = 59;
			recv_idle = 22;
		end
	end

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int unsigned w, h, n, fsize, left;
		logic [23:0] px;
		logic [10:0] wv, hv;
		block_res_t none;
		none = '0;
		mir_shift = 3'd0;
		mir_width = 11'd640;
		mir_height = 11'd480;
		pos_col = 0;
		pos_row = 0;
		foreach (sum_r[i]) begin
			sum_r[i] = '0;
			sum_g[i] = '0;
			sum_b[i] = '0;
		end

		// pass-through after reset, then single-pixel frames
		add_row(ROW_PIXEL, '0, '0, 24'h000000, 1'b1,
			'{10'd0, 10'd0, 7'd1, 7'd1, 8'h00, 8'h00, 8'h00, 1'b0});
		add_row(ROW_PIXEL, '0, '0, 24'hffffff, 1'b1,
			'{10'd1, 10'd0, 7'd1, 7'd1, 8'hff, 8'hff, 8'hff, 1'b0});
		add_row(ROW_PIXEL, '0, '0, 24'h563412, 1'b0, none);
		add_row(ROW_WRITE, bap_pkg::REG_WIDTH, 11'd0, '0, 1'b0, none);
		add_row(ROW_WRITE, bap_pkg::REG_HEIGHT, 11'd0, '0, 1'b0, none);
		add_row(ROW_PIXEL, '0, '0, 24'hc35aa5, 1'b1,
			'{10'd0, 10'd0, 7'd1, 7'd1, 8'ha5, 8'h5a, 8'hc3, 1'b1});
		add_row(ROW_PIXEL, '0, '0, 24'hff00ff, 1'b1,
			'{10'd0, 10'd0, 7'd1, 7'd1, 8'hff, 8'h00, 8'hff, 1'b1});
		// unknown register index leaves everything alone
		add_row(ROW_WRITE, bap_pkg::REG_SPARE, 11'h7ff, '0, 1'b0, none);
		// oversized shift acts as 6, clipped to a 2x2 frame
		add_row(ROW_WRITE, bap_pkg::REG_SHIFT, 11'd7, '0, 1'b0, none);
		add_row(ROW_WRITE, bap_pkg::REG_WIDTH, 11'd2, '0, 1'b0, none);
		add_row(ROW_WRITE, bap_pkg::REG_HEIGHT, 11'd2, '0, 1'b0, none);
		repeat (3) add_row(ROW_PIXEL, '0, '0, 24'hffffff, 1'b0, none);
		add_row(ROW_PIXEL, '0, '0, 24'hffffff, 1'b1,
			'{10'd0, 10'd0, 7'd2, 7'd2, 8'hff, 8'hff, 8'hff, 1'b1});
		// 3x3 frame with 2x2 blocks: full, right-clipped, bottom-clipped, corner
		add_row(ROW_WRITE, bap_pkg::REG_SHIFT, 11'd1, '0, 1'b0, none);
		add_row(ROW_WRITE, bap_pkg::REG_WIDTH, 11'd3, '0, 1'b0, none);
		add_row(ROW_WRITE, bap_pkg::REG_HEIGHT, 11'd3, '0, 1'b0, none);
		for (int i = 0; i < 9; i++)
			add_row(ROW_PIXEL, '0, '0, {8'(i * 29), 8'(255 - i * 17), 8'(i * 31 + 7)},
				1'b0, none);

		cfg_valid <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) write_reg(dir_rows[i].idx, dir_rows[i].val);
			else send_pixel(dir_rows[i].rgb, dir_rows[i].typed, dir_rows[i].want);
		end

		// random phases: new geometry, then mostly whole frames of random pixels
		while (pixels_sent < 2000) begin
			case ($urandom_range(9))
				0: wv = 11'd0;
				1: wv = 11'h7ff;
				2: wv = 11'd1024;
				3: wv = 11'($urandom_range(1, 1023));
				default: wv = 11'($urandom_range(1, 40));
			endcase
			case ($urandom_range(9))
				0: hv = 11'd0;
				1: hv = 11'h7ff;
				default: hv = 11'($urandom_range(1, 12));
			endcase
			write_reg(bap_pkg::REG_HEIGHT, hv);
			write_reg(bap_pkg::REG_SHIFT, 11'($urandom_range(0, 7)));
			write_reg(bap_pkg::REG_WIDTH, wv);
			w = (wv == 0) ? 1 : (wv > bap_pkg::MaxWidth ? bap_pkg::MaxWidth : wv);
			h = (hv == 0) ? 1 : (hv > bap_pkg::MaxHeight ? bap_pkg::MaxHeight : hv);
			fsize = w * h;
			n = (fsize <= 400) ? fsize * $urandom_range(1, 2) : $urandom_range(100, 400);
			left = 2000 - pixels_sent;
			if (n > left) n = left;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(3) == 0)
					px = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
						{8{1'($urandom_range(1))}}};
				else
					px = 24'($urandom);
				send_pixel(px, 1'b0, none);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### block_average_pixelize_core.f
design/bap_pkg.sv
design/bap_ctrl.sv
design/bap_datapath.sv
design/block_average_pixelize_core.sv
bench/tb_top.sv
